[hw/rtl/incremental_transitive_closure_unit_defines.svh]
// Assertion macros shared by the incremental transitive closure RTL.
// Depends on nothing; included by itc_ctrl, the module that carries assertions.
`ifndef INCREMENTAL_TRANSITIVE_CLOSURE_UNIT_DEFINES_SVH
`define INCREMENTAL_TRANSITIVE_CLOSURE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ITC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/itc_pkg.sv]
// Shared types and codes for the incremental transitive closure unit.
// Depends on nothing; used by itc_ctrl, the top module and the testbench.
package itc_pkg;

  localparam int NODE_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CYCLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SELF  = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                connected;
  } result_t;

endpackage

[hw/rtl/itc_row_mem.sv]
// Reachability row store: one row of NODES bits per node.
// Synchronous write, registered read; no package use.
module itc_row_mem #(
  parameter int NODES = 64,
  localparam int IDX_W = $clog2(NODES)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [NODES-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [NODES-1:0] wr_data
);

  logic [NODES-1:0] mem [NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/itc_ctrl.sv]
// Sequencer of the closure unit: clearing pass, lookups and the row sweep.
// Depends on itc_pkg and the assertion macros header; drives itc_row_mem.
`include "incremental_transitive_closure_unit_defines.svh"

module itc_ctrl #(
  parameter int NODES = 64,
  localparam int IDX_W = $clog2(NODES),
  localparam int CNT_W = $clog2(NODES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [itc_pkg::NODE_W-1:0]    source_node,
  input  logic [itc_pkg::NODE_W-1:0]    dest_node,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [NODES-1:0]              rd_data,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [NODES-1:0]              wr_data,
  output logic                          res_valid,
  output itc_pkg::result_t              res,
  input  logic                          res_ready
);
  import itc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [NODES-1:0]  dst_row, dst_row_next;
  result_t           result, result_next;
  logic              op;
  logic [NODE_W-1:0] src;
  logic [NODE_W-1:0] dst;
  logic              rd_pend;
  logic [IDX_W-1:0]  wb_addr;

  logic              accept;
  logic              sweep_rd;
  logic              in_range;
  logic [IDX_W-1:0]  src_idx;
  logic [IDX_W-1:0]  dst_idx;
  logic              row_hit;

  assign accept   = in_valid && in_ready;
  assign in_range = (32'(source_node) < NODES) && (32'(dest_node) < NODES);
  assign src_idx  = IDX_W'(src);
  assign dst_idx  = IDX_W'(dst);
  // A row takes the update when it reaches the source, or is the source row.
  assign row_hit  = rd_data[src_idx] || (wb_addr == src_idx);
  assign res      = result;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    dst_row_next = dst_row;
    result_next  = result;
    in_ready     = (state == S_IDLE);
    res_valid    = (state == S_DONE);
    rd_en        = 1'b0;
    rd_addr      = cnt[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = wb_addr;
    wr_data      = rd_data;
    sweep_rd     = 1'b0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[IDX_W-1:0];
        wr_data = '0;
        if (cnt == CNT_W'(NODES - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          result_next = '{status: ST_OK, connected: 1'b0};
          if (operation == OP_INSERT && source_node == dest_node) begin
            result_next.status = ST_SELF;
            state_next         = S_DONE;
          end else if (!in_range) begin
            state_next = S_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = (operation == OP_QUERY) ? IDX_W'(source_node) : IDX_W'(dest_node);
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (op == OP_QUERY) begin
          result_next.connected = rd_data[dst_idx];
          state_next            = S_DONE;
        end else if (rd_data[src_idx]) begin
          result_next.status = ST_CYCLE;
          state_next         = S_DONE;
        end else begin
          dst_row_next = rd_data | (NODES'(1) << dst_idx);
          cnt_next     = '0;
          state_next   = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (cnt != CNT_W'(NODES)) begin
          sweep_rd = 1'b1;
          rd_en    = 1'b1;
          rd_addr  = cnt[IDX_W-1:0];
          cnt_next = cnt + CNT_W'(1);
        end else begin
          cnt_next   = '0;
          state_next = S_DONE;
        end
        wr_en   = rd_pend;
        wr_data = row_hit ? (rd_data | dst_row) : rd_data;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      rd_pend <= sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    dst_row <= dst_row_next;
    result  <= result_next;
    wb_addr <= cnt[IDX_W-1:0];
    if (accept) begin
      op  <= operation;
      src <= source_node;
      dst <= dest_node;
    end
  end

  `ITC_ASSERT_IMPL(a_no_row_overlap, clk, rst, rd_en && wr_en, rd_addr != wr_addr, "read and write hit the same row")
  `ITC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "accepted a second item while busy")
  `ITC_ASSERT_IMPL(a_result_quiet, clk, rst, res_valid, !rd_en && !wr_en, "memory active while a result is offered")

endmodule

[hw/rtl/incremental_transitive_closure_unit.sv]
// Incremental transitive closure unit over a NODES by NODES reachability bit matrix.
// An insertion that updates the matrix looks up the destination row, then sweeps every row,
// reading each and writing it back; a query or cycle rejection ends after the lookup, and a
// self loop goes straight to the result. One item is in work at a time.
// After reset a clearing pass writes every row to zero, with in_ready low.
// Depends on itc_pkg, itc_ctrl and itc_row_mem.
module incremental_transitive_closure_unit #(
  parameter int NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [itc_pkg::NODE_W-1:0]    source_node,
  input  logic [itc_pkg::NODE_W-1:0]    dest_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itc_pkg::STATUS_W-1:0]  status,
  output logic                          connected
);
  import itc_pkg::*;

  localparam int IDX_W = $clog2(NODES);

  // Memory port between the sequencer and the row store.
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [NODES-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [NODES-1:0] wr_data;

  // Result hand-over from the sequencer to the output register.
  logic    res_valid;
  logic    res_ready;
  result_t res;

  itc_ctrl #(
    .NODES(NODES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .source_node(source_node),
    .dest_node  (dest_node),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  // The sweep reads row k while it writes back row k - 1, so a read and a
  // write never meet on the same row and no forwarding is required.
  itc_row_mem #(
    .NODES(NODES)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Output register: a finished result waits here for its transfer, so the
  // sequencer can return to idle and take the next input item meanwhile.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status    <= res.status;
      connected <= res.connected;
    end
  end

endmodule

[tb/incremental_transitive_closure_unit_tb.sv]
// Self-checking testbench for the incremental transitive closure unit.
// A local reachability matrix predicts the status and the connected flag of every transfer.
// Depends on itc_pkg and incremental_transitive_closure_unit.
`timescale 1ns / 1ps

module incremental_transitive_closure_unit_tb;
  import itc_pkg::*;

  localparam int NODES       = 64;
  localparam int CYCLE_LIMIT = 600000;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                operation   = OP_QUERY;
  logic [NODE_W-1:0]   source_node = '0;
  logic [NODE_W-1:0]   dest_node   = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                connected;

  // Local copy of the reachability matrix: bit d of row s is set when s reaches d.
  logic [NODES-1:0] reach_matrix [NODES];
  result_t          expected_results [$];
  result_t          oldest_expected;

  int  cycle_count = 0;
  int  error_count = 0;
  int  stall_left  = 0;
  bit  in_gaps_on  = 1'b1;
  bit  out_stalls_on = 1'b1;

  incremental_transitive_closure_unit #(
    .NODES(NODES)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .source_node(source_node),
    .dest_node  (dest_node),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .connected  (connected)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // A run that never drains is caught here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly no pause or a short one, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Works out the result of one item and applies an accepted edge to the local matrix.
  function automatic result_t apply_item(logic op, logic [NODE_W-1:0] src,
                                         logic [NODE_W-1:0] dst);
    result_t          res;
    logic [NODES-1:0] dst_row;
    res = '0;
    if (op == OP_QUERY) begin
      if (int'(src) < NODES && int'(dst) < NODES) res.connected = reach_matrix[src][dst];
    end else if (src == dst) begin
      res.status = ST_SELF;
    end else if (int'(src) < NODES && int'(dst) < NODES) begin
      if (reach_matrix[dst][src]) begin
        res.status = ST_CYCLE;
      end else begin
        // Everything that reaches the source now reaches the destination and its successors.
        dst_row      = reach_matrix[dst];
        dst_row[dst] = 1'b1;
        reach_matrix[src] = reach_matrix[src] | dst_row;
        for (int k = 0; k < NODES; k++) begin
          if (reach_matrix[k][src]) reach_matrix[k] = reach_matrix[k] | dst_row;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Sends one item; valid is only lowered when a pause precedes it.
  task automatic send_item(input logic op, input logic [NODE_W-1:0] src,
                           input logic [NODE_W-1:0] dst);
    int      gap;
    result_t predicted;
    gap = in_gaps_on ? idle_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    source_node <= src;
    dest_node   <= dst;
    do @(posedge clk); while (!in_ready);
    predicted = apply_item(op, src, dst);
    expected_results.insert(expected_results.size(), predicted);
  endtask

  task automatic wait_for_results(input int extra_cycles);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  // Random mix: queries, edges that run forward in index order and so build deep chains,
  // backward edges that tend to close cycles, self loops and unrestricted noise.
  task automatic send_random_item();
    int                r;
    int                span;
    logic [NODE_W-1:0] s;
    logic [NODE_W-1:0] d;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      s = NODE_W'($urandom_range(0, NODES - 1));
      d = $urandom_range(0, 1) ? NODE_W'($urandom_range(0, NODES - 1))
                               : NODE_W'(s + $urandom_range(0, 6));
      send_item(OP_QUERY, s, d);
    end else if (r < 80) begin
      s    = NODE_W'($urandom_range(0, NODES - 2));
      span = NODES - 1 - int'(s);
      if (span > 8 && $urandom_range(0, 3) != 0) span = 8;
      d = NODE_W'(int'(s) + $urandom_range(1, span));
      send_item(OP_INSERT, s, d);
    end else if (r < 92) begin
      d = NODE_W'($urandom_range(0, NODES - 2));
      s = NODE_W'($urandom_range(int'(d) + 1, NODES - 1));
      send_item(OP_INSERT, s, d);
    end else if (r < 96) begin
      s = NODE_W'($urandom_range(0, NODES - 1));
      send_item(OP_INSERT, s, s);
    end else begin
      send_item(logic'($urandom_range(0, 1)), NODE_W'($urandom_range(0, NODES - 1)),
                NODE_W'($urandom_range(0, NODES - 1)));
    end
  endtask

  // Result stall generator; it runs whether or not a result is waiting.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= idle_length();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result transfer is compared with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d connected %0d",
                                  status, connected));
      end else begin
        oldest_expected = expected_results.pop_front();
        if (status !== oldest_expected.status)
          report_mismatch($sformatf("status %0d, predicted %0d",
                                    status, oldest_expected.status));
        if (connected !== oldest_expected.connected)
          report_mismatch($sformatf("connected %0d, predicted %0d",
                                    connected, oldest_expected.connected));
      end
    end
  end

  // Empty matrix, self loops, cycle rejection, self queries and propagation along chains.
  task automatic test_directed_cases();
    send_item(OP_QUERY, 6'd0, 6'd63);
    send_item(OP_INSERT, 6'd0, 6'd0);
    send_item(OP_INSERT, 6'd63, 6'd63);
    send_item(OP_QUERY, 6'd5, 6'd5);
    send_item(OP_INSERT, 6'd0, 6'd63);
    send_item(OP_QUERY, 6'd0, 6'd63);
    send_item(OP_QUERY, 6'd63, 6'd0);
    send_item(OP_INSERT, 6'd63, 6'd0);
    send_item(OP_INSERT, 6'd1, 6'd2);
    send_item(OP_INSERT, 6'd2, 6'd3);
    send_item(OP_INSERT, 6'd3, 6'd4);
    send_item(OP_QUERY, 6'd1, 6'd4);
    send_item(OP_INSERT, 6'd4, 6'd1);
    send_item(OP_INSERT, 6'd10, 6'd1);
    send_item(OP_QUERY, 6'd10, 6'd4);
    send_item(OP_INSERT, 6'd4, 6'd42);
    send_item(OP_QUERY, 6'd10, 6'd42);
    send_item(OP_QUERY, 6'd2, 6'd42);
    send_item(OP_INSERT, 6'd42, 6'd21);
    send_item(OP_QUERY, 6'd1, 6'd21);
    send_item(OP_INSERT, 6'd21, 6'd10);
    send_item(OP_QUERY, 6'd21, 6'd21);
    send_item(OP_INSERT, 6'd1, 6'd3);
  endtask

  // Both sides run flat out so items follow each other with no gap.
  task automatic test_back_to_back();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    repeat (40) send_random_item();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // The sender holds off until the block has returned every outstanding result.
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (20) send_random_item();
      wait_for_results(0);
    end
  endtask

  task automatic test_random_traffic();
    repeat (500) send_random_item();
  endtask

  initial begin
    for (int k = 0; k < NODES; k++) reach_matrix[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_back_to_back();
    test_drain_pause();
    test_random_traffic();
    wait_for_results(NODES + 8);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
